[hdl/mpq_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// mpq_pkg : shared types and codes for the priority queue
// Beat payloads, cell entry type, cell command codes and status codes.
// ----------------------------------------------------------------------------
package mpq_pkg;

	localparam int VALUE_W = 32;
	localparam int PRIO_W  = 8;
	localparam int STAT_W  = 2;
	localparam int FILL_W  = 4;

	localparam logic FUNC_INSERT = 1'b0;
	localparam logic FUNC_REMOVE = 1'b1;

	localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
	localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
	localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

	typedef struct packed {
		logic                      func;
		logic signed [VALUE_W-1:0] in_value;
		logic        [PRIO_W-1:0]  in_priority;
	} req_item_t;

	typedef struct packed {
		logic        [STAT_W-1:0]  status;
		logic signed [VALUE_W-1:0] out_value;
		logic        [PRIO_W-1:0]  out_priority;
		logic        [FILL_W-1:0]  fill_level;
	} rsp_item_t;

	typedef struct packed {
		logic signed [VALUE_W-1:0] value;
		logic        [PRIO_W-1:0]  prio;
	} entry_t;

	// hold, append at tail, pop head and requeue at tail, pop head and drop
	typedef enum logic [1:0] {
		CELL_HOLD   = 2'd0,
		CELL_INSERT = 2'd1,
		CELL_RECIRC = 2'd2,
		CELL_DROP   = 2'd3
	} cell_op_t;

endpackage
`default_nettype wire

[hdl/mpq_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// mpq_if : request and response channels
// Valid/ready channels; a beat moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface mpq_req_if;
	logic               valid;
	logic               ready;
	mpq_pkg::req_item_t item;

	modport source (output valid, output item, input ready);
	modport sink (input valid, input item, output ready);
endinterface

interface mpq_rsp_if;
	logic               valid;
	logic               ready;
	mpq_pkg::rsp_item_t item;

	modport source (output valid, output item, input ready);
	modport sink (input valid, input item, output ready);
endinterface
`default_nettype wire

[hdl/mpq_cell.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// mpq_cell : one queue slot
// Holds one entry and its valid bit. Shifts from the next cell toward the
// head, takes the head entry when it is the tail, or loads a new entry.
// ----------------------------------------------------------------------------
module mpq_cell (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire mpq_pkg::cell_op_t op,
	input  wire mpq_pkg::entry_t   ins_entry,
	input  wire mpq_pkg::entry_t   head_entry,
	input  wire mpq_pkg::entry_t   next_entry,
	input  wire logic              next_valid,
	input  wire logic              prev_valid,
	output mpq_pkg::entry_t        entry,
	output logic                   valid
);

	mpq_pkg::entry_t entry_q;
	logic            valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			case (op)
				mpq_pkg::CELL_INSERT: begin
					if (!valid_q && prev_valid) begin
						valid_q <= 1'b1;
					end
				end
				mpq_pkg::CELL_DROP: begin
					if (!next_valid) begin
						valid_q <= 1'b0;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (op)
			mpq_pkg::CELL_INSERT: begin
				if (!valid_q && prev_valid) begin
					entry_q <= ins_entry;
				end
			end
			mpq_pkg::CELL_RECIRC: begin
				if (next_valid) begin
					entry_q <= next_entry;
				end else if (valid_q) begin
					entry_q <= head_entry;
				end
			end
			mpq_pkg::CELL_DROP: begin
				if (next_valid) begin
					entry_q <= next_entry;
				end
			end
			default: begin
			end
		endcase
	end

	assign entry = entry_q;
	assign valid = valid_q;

endmodule
`default_nettype wire

[hdl/max_priority_queue_fifo_ties_unit.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// max_priority_queue_fifo_ties_unit : bounded priority queue, FIFO on ties
// Entries sit in a row of cells in arrival order; remove serves the oldest
// entry of the highest priority.
//
//   channel | dir | beat payload
//   --------+-----+---------------------------------------------------
//   req     | in  | func, in_value, in_priority
//   rsp     | out | status, out_value, out_priority, fill_level
//
// Insert, full insert and empty remove: result registered in the cycle after
// the request beat. Remove from a non-empty queue: a scan rotates the row one
// cell per cycle past the head until every entry has passed it once, then the
// result is registered. Reset empties the queue at once. req.ready is low
// during a scan and while an unaccepted result sits in the output register.
// ----------------------------------------------------------------------------
module max_priority_queue_fifo_ties_unit #(
	parameter int DEPTH = 8
) (
	input wire logic clk,
	input wire logic arst_n,
	mpq_req_if.sink  req,
	mpq_rsp_if.source rsp
);

	localparam int CW     = $clog2(DEPTH + 1);
	localparam int FILL_W = mpq_pkg::FILL_W;
	localparam int PW     = mpq_pkg::PRIO_W;

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_SCAN = 2'b10
	} state_t;

	state_t             state_q;
	logic [CW-1:0]      count_q;
	logic [CW-1:0]      steps_q;
	logic [PW-1:0]      highest_q;
	logic [PW-1:0]      runmax_q;
	logic               found_q;
	mpq_pkg::entry_t    cap_q;
	logic               rsp_valid_q;
	mpq_pkg::rsp_item_t rsp_item_q;

	mpq_pkg::entry_t    cell_entry [DEPTH];
	logic [DEPTH-1:0]   cell_valid;
	mpq_pkg::cell_op_t  cell_op;
	mpq_pkg::entry_t    ins_entry;
	mpq_pkg::entry_t    head;

	logic               accept;
	logic               is_insert;
	logic               full;
	logic               empty;
	logic               head_match;
	logic               last_step;
	logic               rsp_load;
	logic [PW-1:0]      final_max;

	assign head      = cell_entry[0];
	assign accept    = req.valid && req.ready;
	assign is_insert = req.item.func == mpq_pkg::FUNC_INSERT;
	assign full      = count_q == CW'(DEPTH);
	assign empty     = count_q == '0;
	assign head_match = !found_q && (head.prio == highest_q);
	assign last_step = (state_q == S_SCAN) && (steps_q == CW'(1));
	assign rsp_load  = ((state_q == S_IDLE) && accept && (is_insert || empty)) || last_step;
	assign final_max = (head_match || head.prio <= runmax_q) ? runmax_q : head.prio;

	assign ins_entry.value = req.item.in_value;
	assign ins_entry.prio  = req.item.in_priority;

	assign req.ready = (state_q == S_IDLE) && (!rsp_valid_q || rsp.ready);
	assign rsp.valid = rsp_valid_q;
	assign rsp.item  = rsp_item_q;

	always_comb begin
		cell_op = mpq_pkg::CELL_HOLD;
		if (state_q == S_SCAN) begin
			cell_op = head_match ? mpq_pkg::CELL_DROP : mpq_pkg::CELL_RECIRC;
		end else if (accept && is_insert && !full) begin
			cell_op = mpq_pkg::CELL_INSERT;
		end
	end

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		mpq_pkg::entry_t next_entry;
		logic            next_valid;
		logic            prev_valid;

		if (i == DEPTH - 1) begin : g_tail
			assign next_entry = cell_entry[i];
			assign next_valid = 1'b0;
		end else begin : g_mid
			assign next_entry = cell_entry[i+1];
			assign next_valid = cell_valid[i+1];
		end

		if (i == 0) begin : g_head
			assign prev_valid = 1'b1;
		end else begin : g_rest
			assign prev_valid = cell_valid[i-1];
		end

		mpq_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.op         (cell_op),
			.ins_entry  (ins_entry),
			.head_entry (head),
			.next_entry (next_entry),
			.next_valid (next_valid),
			.prev_valid (prev_valid),
			.entry      (cell_entry[i]),
			.valid      (cell_valid[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			steps_q     <= '0;
			highest_q   <= '0;
			found_q     <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (is_insert) begin
							if (!full) begin
								count_q <= count_q + CW'(1);
								if (req.item.in_priority > highest_q) begin
									highest_q <= req.item.in_priority;
								end
							end
						end else if (!empty) begin
							state_q <= S_SCAN;
							steps_q <= count_q;
							found_q <= 1'b0;
						end
					end
				end
				S_SCAN: begin
					steps_q <= steps_q - CW'(1);
					if (head_match) begin
						found_q <= 1'b1;
					end
					if (last_step) begin
						state_q   <= S_IDLE;
						count_q   <= count_q - CW'(1);
						highest_q <= final_max;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && accept) begin
			runmax_q <= '0;
			rsp_item_q.out_value    <= '0;
			rsp_item_q.out_priority <= '0;
			if (is_insert) begin
				if (full) begin
					rsp_item_q.status     <= mpq_pkg::ST_FULL;
					rsp_item_q.fill_level <= FILL_W'(count_q);
				end else begin
					rsp_item_q.status     <= mpq_pkg::ST_OK;
					rsp_item_q.fill_level <= FILL_W'(count_q + CW'(1));
				end
			end else begin
				rsp_item_q.status     <= mpq_pkg::ST_EMPTY;
				rsp_item_q.fill_level <= FILL_W'(count_q);
			end
		end
		if (state_q == S_SCAN) begin
			if (head_match) begin
				cap_q <= head;
			end else if (head.prio > runmax_q) begin
				runmax_q <= head.prio;
			end
			if (last_step) begin
				rsp_item_q.status       <= mpq_pkg::ST_OK;
				rsp_item_q.out_value    <= head_match ? head.value : cap_q.value;
				rsp_item_q.out_priority <= head_match ? head.prio : cap_q.prio;
				rsp_item_q.fill_level   <= FILL_W'(count_q - CW'(1));
			end
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("entry count above depth");

	a_valid_matches_count: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_IDLE |-> CW'($countones(cell_valid)) == count_q)
		else $error("occupied cells disagree with entry count");

	a_scan_finds_max: assert property (@(posedge clk) disable iff (!arst_n)
		last_step |-> (found_q || head_match))
		else $error("scan ended without a highest-priority entry");

	a_scan_head_valid: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SCAN |-> cell_valid[0])
		else $error("scan with empty head cell");

endmodule
`default_nettype wire

[tb/sv/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top : self-checking bench for max_priority_queue_fifo_ties_unit
// Drives insert/remove requests with random gaps on both channels. A shadow
// queue in arrival order predicts every response beat, which is compared
// field by field as it arrives.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int DEPTH       = 8;
	localparam int FILL_W      = mpq_pkg::FILL_W;
	localparam int CYCLE_LIMIT = 200000;
	localparam int QUIET_START = 2000;
	localparam int QUIET_END   = 5000;

	logic clk = 1'b0;
	logic arst_n;

	mpq_req_if req_ch ();
	mpq_rsp_if rsp_ch ();

	max_priority_queue_fifo_ties_unit #(.DEPTH(DEPTH)) DUT (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_ch),
		.rsp   (rsp_ch)
	);

	mpq_pkg::req_item_t req_backlog[$];
	mpq_pkg::rsp_item_t awaited_rsp[$];
	mpq_pkg::entry_t    shadow_queue[$];
	logic       req_taken = 1'b0;
	int         cycle_count = 0;
	int         error_count = 0;
	int         n_results = 0;
	int         n_removed = 0;
	int         n_full = 0;
	int         n_empty = 0;

	always #5 clk = ~clk;

	function automatic bit idle_now();
		if (cycle_count >= QUIET_START && cycle_count < QUIET_END)
			return 1'b0;
		return $urandom_range(0, 99) < 7;
	endfunction

	// one request against the shadow queue; oldest entry wins on equal priority
	function automatic mpq_pkg::rsp_item_t serve_request(mpq_pkg::req_item_t r);
		mpq_pkg::rsp_item_t res;
		mpq_pkg::entry_t    e;
		int                 pick;
		res = '0;
		if (r.func == mpq_pkg::FUNC_INSERT) begin
			if (shadow_queue.size() >= DEPTH) begin
				res.status = mpq_pkg::ST_FULL;
			end else begin
				e.value = r.in_value;
				e.prio  = r.in_priority;
				shadow_queue.push_back(e);
				res.status = mpq_pkg::ST_OK;
			end
		end else begin
			if (shadow_queue.size() == 0) begin
				res.status = mpq_pkg::ST_EMPTY;
			end else begin
				pick = 0;
				for (int k = 1; k < shadow_queue.size(); k++)
					if (shadow_queue[k].prio > shadow_queue[pick].prio)
						pick = k;
				res.status       = mpq_pkg::ST_OK;
				res.out_value    = shadow_queue[pick].value;
				res.out_priority = shadow_queue[pick].prio;
				shadow_queue.delete(pick);
			end
		end
		res.fill_level = FILL_W'(shadow_queue.size());
		return res;
	endfunction

	task automatic flag_error(string what, logic [31:0] got, logic [31:0] want);
		error_count++;
		if (error_count <= 10)
			$display("%0t: %s mismatch: expected %0h, got %0h", $realtime, what, want, got);
	endtask

	task automatic check_rsp(mpq_pkg::rsp_item_t got);
		mpq_pkg::rsp_item_t want;
		if (awaited_rsp.size() == 0) begin
			error_count++;
			if (error_count <= 10)
				$display("%0t: response beat with nothing expected (status %0d, value %0h)",
					$realtime, got.status, got.out_value);
			return;
		end
		want = awaited_rsp.pop_front();
		if (got.status !== want.status)
			flag_error("status", 32'(got.status), 32'(want.status));
		if (got.out_value !== want.out_value)
			flag_error("out_value", got.out_value, want.out_value);
		if (got.out_priority !== want.out_priority)
			flag_error("out_priority", 32'(got.out_priority), 32'(want.out_priority));
		if (got.fill_level !== want.fill_level)
			flag_error("fill_level", 32'(got.fill_level), 32'(want.fill_level));
	endtask

	task automatic add_req(logic func, logic [31:0] value, logic [7:0] prio);
		mpq_pkg::req_item_t r;
		r.func        = func;
		r.in_value    = value;
		r.in_priority = prio;
		req_backlog.push_back(r);
	endtask

	// monitor: sample both channels at the rising edge
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb_top: timeout after %0d cycles", cycle_count);
			$display("tb_top: done, errors");
			$finish;
		end else if (arst_n) begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				n_results++;
				if (rsp_ch.item.status == mpq_pkg::ST_FULL)
					n_full++;
				if (rsp_ch.item.status == mpq_pkg::ST_EMPTY)
					n_empty++;
				check_rsp(rsp_ch.item);
			end
			if (req_ch.valid && req_ch.ready) begin
				if (req_ch.item.func == mpq_pkg::FUNC_REMOVE && shadow_queue.size() > 0)
					n_removed++;
				awaited_rsp.push_back(serve_request(req_ch.item));
			end
			req_taken <= req_ch.valid && req_ch.ready;
		end
	end

	// driver: change inputs at the falling edge
	always @(negedge clk) begin
		if (arst_n) begin
			if (!req_ch.valid || req_taken) begin
				if (req_backlog.size() > 0 && !idle_now()) begin
					req_ch.item  <= req_backlog.pop_front();
					req_ch.valid <= 1'b1;
				end else begin
					req_ch.valid <= 1'b0;
				end
			end
			rsp_ch.ready <= !idle_now();
		end
	end

	initial begin
		int ins_pct;
		int prio_mode;
		logic [7:0] p;
		req_ch.valid = 1'b0;
		req_ch.item  = '0;
		rsp_ch.ready = 1'b0;
		arst_n       = 1'b0;

		// directed: empty remove, fill with extremes and ties, full insert, drain
		add_req(mpq_pkg::FUNC_REMOVE, 32'hFFFF_FFFF, 8'hFF);
		add_req(mpq_pkg::FUNC_INSERT, 32'h8000_0000, 8'd0);
		add_req(mpq_pkg::FUNC_INSERT, 32'h7FFF_FFFF, 8'd255);
		add_req(mpq_pkg::FUNC_INSERT, 32'hFFFF_FFFF, 8'd128);
		add_req(mpq_pkg::FUNC_INSERT, 32'h0000_0000, 8'd255);
		add_req(mpq_pkg::FUNC_INSERT, 32'h5555_5555, 8'd128);
		add_req(mpq_pkg::FUNC_INSERT, 32'hAAAA_AAAA, 8'd1);
		add_req(mpq_pkg::FUNC_INSERT, 32'h1234_5678, 8'd255);
		add_req(mpq_pkg::FUNC_INSERT, 32'h0000_0001, 8'd0);
		add_req(mpq_pkg::FUNC_INSERT, 32'hDEAD_BEEF, 8'd200);
		for (int i = 0; i < DEPTH; i++)
			add_req(mpq_pkg::FUNC_REMOVE, 32'(i), 8'(i * 37));
		add_req(mpq_pkg::FUNC_REMOVE, 32'h0, 8'h0);
		add_req(mpq_pkg::FUNC_INSERT, 32'h0000_0005, 8'd0);
		add_req(mpq_pkg::FUNC_REMOVE, 32'h7FFF_FFFF, 8'd255);

		// random: blocks that lean toward filling or draining, or stay balanced
		for (int blk = 0; blk < 24; blk++) begin
			case ($urandom_range(0, 2))
				0: ins_pct = 25;
				1: ins_pct = 50;
				default: ins_pct = 80;
			endcase
			prio_mode = $urandom_range(0, 3);
			for (int i = 0; i < 40; i++) begin
				case (prio_mode)
					0: p = 8'($urandom_range(0, 3));
					1: p = $urandom_range(0, 1) ? 8'd255 : 8'd0;
					2: p = 8'($urandom_range(250, 255));
					default: p = 8'($urandom);
				endcase
				if ($urandom_range(0, 99) < ins_pct)
					add_req(mpq_pkg::FUNC_INSERT, $urandom, p);
				else
					add_req(mpq_pkg::FUNC_REMOVE, $urandom, 8'($urandom));
			end
		end

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (req_backlog.size() > 0 || req_ch.valid || awaited_rsp.size() > 0)
			@(negedge clk);
		repeat (2 * DEPTH + 8) @(negedge clk);

		$display("tb_top: %0d responses checked, %0d removals served", n_results, n_removed);
		$display("tb_top: %0d inserts refused as full, %0d removes on empty queue",
			n_full, n_empty);
		if (error_count == 0) begin
			$display("tb_top: done, clean");
		end else begin
			$display("tb_top: %0d mismatches", error_count);
			$display("tb_top: done, errors");
		end
		$finish;
	end

endmodule
